/* rtl/core/bdst_pkg.sv */
// ----------------------------------------------------------------------------
// bdst_pkg
// shared constants, register codes and types of the burst dma slip tracker
// ----------------------------------------------------------------------------
package bdst_pkg;

  localparam int LockoutBurstsDef = 8;
  localparam int BaseLengthDef    = 312;

  localparam int LockW  = 4;
  localparam int CntW   = 32;
  localparam int LenW   = 13;
  localparam int PwrW   = 16;
  localparam int DevW   = 16;
  localparam int TrimW  = 8;
  localparam int LoadW  = 16;
  localparam int PeakW  = 7;
  localparam int CfgIdxW = 2;

  // arming and deviation
  localparam logic [31:0]            ArmDiff  = 32'd12;
  localparam logic [DevW-1:0]        RefStep  = 16'd12;
  localparam logic signed [DevW-1:0] DevLimit = 16'sd12;

  // correction (d*1365+4)>>14
  localparam int CorrW = 28;
  localparam logic signed [CorrW-1:0] CorrMul = 28'sd1365;
  localparam logic signed [CorrW-1:0] CorrRnd = 28'sd4;
  localparam int CorrShift = 14;
  localparam int CorrOutW  = CorrW - CorrShift;

  // load percentage: floor(diff*100/312) as (diff*336100)>>20 for diff <= 315
  localparam logic [LoadW-1:0] LoadDiffMax = 16'd315;
  localparam int               PctDiffW    = 9;
  localparam logic [18:0]      PctMul      = 19'd336100;
  localparam int               PctShift    = 20;
  localparam int               PctProdW    = 28;

  // register codes
  localparam logic [CfgIdxW-1:0] CfgBasePower = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPowerMin  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPowerMax  = 2'd2;

  localparam logic signed [PwrW-1:0] BasePowerRst = 16'sd0;
  localparam logic signed [PwrW-1:0] PowerMinRst  = 16'sd0;
  localparam logic signed [PwrW-1:0] PowerMaxRst  = 16'sd4095;

  typedef struct packed {
    logic                   slip_seen;
    logic signed [DevW-1:0] deviation;
    logic [CntW-1:0]        total;
    logic signed [LenW-1:0] length;
  } slip_res_t;

endpackage

/* rtl/core/bdst_slip.sv */
// ----------------------------------------------------------------------------
// bdst_slip
// arming, even/odd reference, slip detection with lockout and dma length
// ----------------------------------------------------------------------------
module bdst_slip import bdst_pkg::*; #(
  parameter int LOCKOUT_BURSTS = LockoutBurstsDef,
  parameter int BASE_LENGTH    = BaseLengthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [31:0]             offset_count_i,
  input  logic [31:0]             sync_count_i,
  input  logic signed [TrimW-1:0] length_trim_i,
  output slip_res_t               res_o
);

  logic                     locked_q, locked_d;
  logic                     phase_q, phase_d;
  logic [LockW-1:0]         lockout_q, lockout_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     long_q, long_d;

  logic [31:0]              diff_raw;
  logic                     arm_hit;
  logic signed [DevW-1:0]   dev;
  logic                     big;
  logic                     slip;
  logic signed [CorrW-1:0]  prod;
  logic signed [CorrW-1:0]  corr_sum;
  logic signed [CorrOutW-1:0] corr;
  logic [15:0]              len_sum;

  assign diff_raw = offset_count_i - sync_count_i;
  assign arm_hit  = (diff_raw == ArmDiff);
  assign dev      = $signed(diff_raw[DevW-1:0] - (phase_q ? RefStep : '0));
  assign big      = (dev >= DevLimit) || (dev <= -DevLimit);
  assign slip     = locked_q && big && (lockout_q == '0);

  assign prod     = $signed({{(CorrW-DevW){dev[DevW-1]}}, dev}) * CorrMul;
  assign corr_sum = prod + CorrRnd;
  assign corr     = slip ? corr_sum[CorrW-1:CorrShift] : '0;

  assign long_d   = ~long_q;
  assign len_sum  = 16'(BASE_LENGTH) + {15'd0, long_d}
                  + {{(16-TrimW){length_trim_i[TrimW-1]}}, length_trim_i}
                  + {{(16-CorrOutW){corr[CorrOutW-1]}}, corr};

  always_comb begin
    locked_d  = locked_q;
    phase_d   = phase_q;
    lockout_d = lockout_q;
    if (!locked_q) begin
      if (arm_hit) begin
        locked_d = 1'b1;
        phase_d  = 1'b0;
      end
    end else begin
      phase_d = ~phase_q;
      if (slip) begin
        lockout_d = LockW'(LOCKOUT_BURSTS);
      end else if (big) begin
        lockout_d = lockout_q - LockW'(1);
      end
    end
  end

  assign cnt_d = cnt_q + {{(CntW-1){1'b0}}, slip};

  assign res_o.slip_seen = slip;
  assign res_o.deviation = slip ? dev : '0;
  assign res_o.total     = cnt_d;
  assign res_o.length    = $signed(len_sum[LenW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q  <= 1'b0;
      phase_q   <= 1'b0;
      lockout_q <= '0;
      cnt_q     <= '0;
      long_q    <= 1'b0;
    end else if (step_i) begin
      locked_q  <= locked_d;
      phase_q   <= phase_d;
      lockout_q <= lockout_d;
      cnt_q     <= cnt_d;
      long_q    <= long_d;
    end
  end

  a_lockout_needs_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lockout_q != '0) |-> locked_q)
    else $error("lockout running while not armed");

  a_slip_loads_lockout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && slip) |=> (lockout_q == LockW'(LOCKOUT_BURSTS)))
    else $error("lockout not reloaded after slip");

  a_slip_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && slip) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("slip counter did not advance");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(lockout_q) && $stable(long_q) && $stable(phase_q)))
    else $error("tracker state moved without a word");

endmodule

/* rtl/core/bdst_power.sv */
// ----------------------------------------------------------------------------
// bdst_power
// power control registers and clamped downlink power value
// ----------------------------------------------------------------------------
module bdst_power import bdst_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [PwrW-1:0]        cfg_data_i,
  input  logic signed [PwrW-1:0] temp_delta_i,
  output logic signed [PwrW-1:0] dl_power_o
);

  logic signed [PwrW-1:0] base_q, min_q, max_q;
  logic signed [PwrW-1:0] sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BasePowerRst;
      min_q  <= PowerMinRst;
      max_q  <= PowerMaxRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgBasePower: base_q <= $signed(cfg_data_i);
        CfgPowerMin:  min_q  <= $signed(cfg_data_i);
        CfgPowerMax:  max_q  <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign sum = base_q + temp_delta_i;

  always_comb begin
    if (sum > max_q) begin
      dl_power_o = max_q;
    end else if (sum < min_q) begin
      dl_power_o = min_q;
    end else begin
      dl_power_o = sum;
    end
  end

endmodule

/* rtl/core/bdst_load.sv */
// ----------------------------------------------------------------------------
// bdst_load
// cpu load percentage from transfer counter readings and its running peak
// ----------------------------------------------------------------------------
module bdst_load import bdst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [LoadW-1:0] load_start_i,
  input  logic [LoadW-1:0] load_end_i,
  output logic [PeakW-1:0] peak_o
);

  logic [PeakW-1:0]    peak_q, peak_d;
  logic [LoadW-1:0]    diff;
  logic                in_range;
  logic [PctProdW-1:0] prod;
  logic [PeakW-1:0]    pct;

  assign diff     = load_start_i - load_end_i;
  assign in_range = (load_start_i >= load_end_i) && (diff <= LoadDiffMax);
  assign prod     = PctProdW'(diff[PctDiffW-1:0]) * PctProdW'(PctMul);
  assign pct      = prod[PctShift+PeakW-1:PctShift];
  assign peak_d   = (in_range && (pct > peak_q)) ? pct : peak_q;
  assign peak_o   = peak_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
    end else if (step_i) begin
      peak_q <= peak_d;
    end
  end

endmodule

/* rtl/core/burst_dma_slip_tracker.sv */
// ----------------------------------------------------------------------------
// burst_dma_slip_tracker
// burst tick slip tracker, dma length, downlink power and peak load
// ----------------------------------------------------------------------------
// One input word per burst tick gives one result word. A word is captured in
// an input register and its result is formed in a single pass into the
// output register, so a new word is taken every cycle while the output is not
// stalled; out_valid_o rises as the word moves into the output register. The
// tracker state (arming, phase, lockout, slip count, length toggle, load
// peak) is updated at that same move, and the input register can take one
// more word while a finished result waits on out_stall_i. Configuration
// writes are always ready and take effect for words processed afterwards.
// ----------------------------------------------------------------------------
module burst_dma_slip_tracker import bdst_pkg::*; #(
  parameter int LOCKOUT_BURSTS = LockoutBurstsDef,
  parameter int BASE_LENGTH    = BaseLengthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [PwrW-1:0]         cfg_data_i,

  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [31:0]             offset_count_i,
  input  logic [31:0]             sync_count_i,
  input  logic signed [TrimW-1:0] length_trim_i,
  input  logic signed [PwrW-1:0]  temp_delta_i,
  input  logic [LoadW-1:0]        load_start_i,
  input  logic [LoadW-1:0]        load_end_i,

  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [LenW-1:0]  dma_length_o,
  output logic signed [PwrW-1:0]  dl_power_o,
  output logic                    slip_seen_o,
  output logic signed [DevW-1:0]  slip_deviation_o,
  output logic [CntW-1:0]         slip_total_o,
  output logic [PeakW-1:0]        peak_load_o
);

  logic                    s1_valid_q, s1_valid_d;
  logic [31:0]             offset_q, sync_q;
  logic signed [TrimW-1:0] trim_q;
  logic signed [PwrW-1:0]  tdelta_q;
  logic [LoadW-1:0]        lstart_q, lend_q;

  logic                    out_valid_q, out_valid_d;
  logic signed [LenW-1:0]  len_q;
  logic signed [PwrW-1:0]  pwr_q;
  logic                    slip_q;
  logic signed [DevW-1:0]  dev_q;
  logic [CntW-1:0]         total_q;
  logic [PeakW-1:0]        peak_q;

  logic                    adv;
  logic                    step;
  logic                    in_take;
  slip_res_t               slip_res;
  logic signed [PwrW-1:0]  pwr;
  logic [PeakW-1:0]        peak;

  assign cfg_ready_o = 1'b1;

  assign adv        = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && adv;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_take ? 1'b1 : (step ? 1'b0 : s1_valid_q);
  assign out_valid_d = adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      offset_q <= offset_count_i;
      sync_q   <= sync_count_i;
      trim_q   <= length_trim_i;
      tdelta_q <= temp_delta_i;
      lstart_q <= load_start_i;
      lend_q   <= load_end_i;
    end
  end

  bdst_slip #(
    .LOCKOUT_BURSTS (LOCKOUT_BURSTS),
    .BASE_LENGTH    (BASE_LENGTH)
  ) u_slip (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .offset_count_i (offset_q),
    .sync_count_i   (sync_q),
    .length_trim_i  (trim_q),
    .res_o          (slip_res)
  );

  bdst_power u_power (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .temp_delta_i (tdelta_q),
    .dl_power_o   (pwr)
  );

  bdst_load u_load (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .load_start_i (lstart_q),
    .load_end_i   (lend_q),
    .peak_o       (peak)
  );

  always_ff @(posedge clk_i) begin
    if (step) begin
      len_q   <= slip_res.length;
      pwr_q   <= pwr;
      slip_q  <= slip_res.slip_seen;
      dev_q   <= slip_res.deviation;
      total_q <= slip_res.total;
      peak_q  <= peak;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign dma_length_o     = len_q;
  assign dl_power_o       = pwr_q;
  assign slip_seen_o      = slip_q;
  assign slip_deviation_o = dev_q;
  assign slip_total_o     = total_q;
  assign peak_load_o      = peak_q;

endmodule

/* tb/sv/burst_dma_slip_tracker_tb.sv */
// ----------------------------------------------------------------------------
// burst_dma_slip_tracker_tb
// self-checking bench: burst words are driven in bursts with gaps, each
// accepted word is run through a local tracker model, and every result word
// is checked in order against it while the output side stalls on its own
// pattern. covers arming, slips, lockout, power clamping, load peak and a
// long output hold that backs up the input.
// ----------------------------------------------------------------------------
module burst_dma_slip_tracker_tb import bdst_pkg::*; ();

  localparam int IdleLimit  = 2000;
  localparam int HoldCycles = 160;
  localparam int PhaseWords = 250;
  localparam int NumPhases  = 5;
  localparam int MaxReports = 10;

  localparam int ArmOffset  = 12;
  localparam int RefOdd     = 12;
  localparam int SlipLimit  = 12;
  localparam int ScaleMul   = 1365;
  localparam int ScaleRnd   = 4;
  localparam int ScaleShift = 14;
  localparam int PctScale   = 100;
  localparam int LoadWindow = 312;

  typedef enum int {StallNone, StallLight, StallPattern, StallHeavy} stall_mode_e;

  typedef struct packed {
    logic [31:0]             offset;
    logic [31:0]             sync;
    logic signed [TrimW-1:0] trim;
    logic signed [PwrW-1:0]  tdelta;
    logic [LoadW-1:0]        lstart;
    logic [LoadW-1:0]        lend;
  } tick_t;

  typedef struct packed {
    logic signed [LenW-1:0] dma_length;
    logic signed [PwrW-1:0] dl_power;
    logic                   slip_seen;
    logic signed [DevW-1:0] slip_deviation;
    logic [CntW-1:0]        slip_total;
    logic [PeakW-1:0]       peak_load;
  } burst_res_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CfgIdxW-1:0]      cfg_index_i;
  logic [PwrW-1:0]         cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [31:0]             offset_count_i;
  logic [31:0]             sync_count_i;
  logic signed [TrimW-1:0] length_trim_i;
  logic signed [PwrW-1:0]  temp_delta_i;
  logic [LoadW-1:0]        load_start_i;
  logic [LoadW-1:0]        load_end_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [LenW-1:0]  dma_length_o;
  logic signed [PwrW-1:0]  dl_power_o;
  logic                    slip_seen_o;
  logic signed [DevW-1:0]  slip_deviation_o;
  logic [CntW-1:0]         slip_total_o;
  logic [PeakW-1:0]        peak_load_o;

  burst_dma_slip_tracker i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .offset_count_i   (offset_count_i),
    .sync_count_i     (sync_count_i),
    .length_trim_i    (length_trim_i),
    .temp_delta_i     (temp_delta_i),
    .load_start_i     (load_start_i),
    .load_end_i       (load_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .dma_length_o     (dma_length_o),
    .dl_power_o       (dl_power_o),
    .slip_seen_o      (slip_seen_o),
    .slip_deviation_o (slip_deviation_o),
    .slip_total_o     (slip_total_o),
    .peak_load_o      (peak_load_o)
  );

  // tracker model state and register copies
  logic                   trk_armed   = 1'b0;
  logic                   trk_odd     = 1'b0;
  logic                   trk_long    = 1'b0;
  logic [LockW-1:0]       trk_lockout = '0;
  logic [CntW-1:0]        trk_slips   = '0;
  logic [PeakW-1:0]       trk_peak    = '0;
  logic signed [PwrW-1:0] reg_base_power = BasePowerRst;
  logic signed [PwrW-1:0] reg_power_min  = PowerMinRst;
  logic signed [PwrW-1:0] reg_power_max  = PowerMaxRst;

  burst_res_t  burst_results_q[$];

  int unsigned words_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned slips_seen   = 0;
  int unsigned reg_writes   = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_tick   = 0;
  int          burst_max;
  int          gap_max;
  int          burst_left;
  bit          valid_high;
  logic        hold_on;
  stall_mode_e stall_mode;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic burst_res_t track_burst(tick_t t);
    logic [31:0]            diff;
    int                     dev;
    int                     corr;
    int                     len;
    int                     pct;
    logic signed [PwrW-1:0] pwr;
    burst_res_t             r;
    r    = '0;
    corr = 0;
    if (!trk_armed) begin
      if (t.offset - t.sync == 32'(ArmOffset)) begin
        trk_armed = 1'b1;
        trk_odd   = 1'b0;
      end
    end else begin
      diff    = t.offset - t.sync - (trk_odd ? 32'(RefOdd) : 32'd0);
      dev     = int'($signed(diff[15:0]));
      trk_odd = !trk_odd;
      if (dev <= -SlipLimit || dev >= SlipLimit) begin
        if (trk_lockout == 0) begin
          trk_slips        = trk_slips + CntW'(1);
          r.slip_seen      = 1'b1;
          r.slip_deviation = diff[15:0];
          corr             = (dev * ScaleMul + ScaleRnd) >>> ScaleShift;
          trk_lockout      = LockW'(LockoutBurstsDef);
        end else begin
          trk_lockout = trk_lockout - LockW'(1);
        end
      end
    end
    trk_long = !trk_long;
    len = BaseLengthDef + int'(trk_long) + int'($signed(t.trim)) + corr;
    r.dma_length = len[LenW-1:0];

    pwr = reg_base_power + t.tdelta;
    if (pwr > reg_power_max) begin
      pwr = reg_power_max;
    end else if (pwr < reg_power_min) begin
      pwr = reg_power_min;
    end
    r.dl_power = pwr;

    if (t.lstart >= t.lend) begin
      pct = (int'(t.lstart) - int'(t.lend)) * PctScale / LoadWindow;
      if (pct > int'(trk_peak) && pct <= PctScale) begin
        trk_peak = pct[PeakW-1:0];
      end
    end
    r.slip_total = trk_slips;
    r.peak_load  = trk_peak;
    return r;
  endfunction

  // receiver stall pattern, plus the long hold
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      StallLight:   out_stall_i <= hold_on || ($urandom_range(0, 3) == 0);
      StallPattern: out_stall_i <= hold_on || ((stall_tick % 11) < 4);
      StallHeavy:   out_stall_i <= hold_on || ($urandom_range(0, 3) != 0);
      default:      out_stall_i <= hold_on;
    endcase
  end

  always @(posedge clk_i) begin : check_results
    burst_res_t want;
    burst_res_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{dma_length_o, dl_power_o, slip_seen_o, slip_deviation_o, slip_total_o,
              peak_load_o};
      results_seen++;
      if (slip_seen_o) slips_seen++;
      if (burst_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("result word %0d with nothing pending: %p", results_seen, got);
        end
      end else begin
        want = burst_results_q.pop_front();
        if (got.dma_length !== want.dma_length || got.dl_power !== want.dl_power ||
            got.slip_seen !== want.slip_seen || got.slip_deviation !== want.slip_deviation ||
            got.slip_total !== want.slip_total || got.peak_load !== want.peak_load) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("result word %0d mismatch (exp/act): len %0d/%0d pwr %0d/%0d",
                     results_seen, want.dma_length, got.dma_length, want.dl_power,
                     got.dl_power);
            $display("  slip %0b/%0b dev %0d/%0d total %0d/%0d peak %0d/%0d",
                     want.slip_seen, got.slip_seen, want.slip_deviation,
                     got.slip_deviation, want.slip_total, got.slip_total,
                     want.peak_load, got.peak_load);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("watchdog: no word moved for %0d cycles", IdleLimit);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(tick_t t);
    in_valid_i     <= 1'b1;
    offset_count_i <= t.offset;
    sync_count_i   <= t.sync;
    length_trim_i  <= t.trim;
    temp_delta_i   <= t.tdelta;
    load_start_i   <= t.lstart;
    load_end_i     <= t.lend;
    valid_high = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    burst_results_q.push_back(track_burst(t));
    words_sent++;
    if (gap_max > 0) begin
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        in_valid_i <= 1'b0;
        valid_high = 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
        burst_left = $urandom_range(1, burst_max);
      end
    end
  endtask

  // offset placed at the given deviation from the current even/odd reference
  task automatic send_offset(int dev, int unsigned upper, tick_t t);
    t.sync   = $urandom;
    t.offset = t.sync + (trk_odd ? RefOdd : 0) + dev + (upper << 16);
    send_word(t);
  endtask

  task automatic drain_results();
    if (valid_high) begin
      in_valid_i <= 1'b0;
      valid_high = 1'b0;
      @(posedge clk_i);
    end
    while (burst_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_power(logic signed [PwrW-1:0] base, logic signed [PwrW-1:0] pmin,
                               logic signed [PwrW-1:0] pmax);
    logic [CfgIdxW-1:0] idx [3];
    logic [PwrW-1:0]    val [3];
    drain_results();
    idx = '{CfgBasePower, CfgPowerMin, CfgPowerMax};
    val = '{base, pmin, pmax};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[i])
        CfgBasePower: reg_base_power = val[i];
        CfgPowerMin:  reg_power_min  = val[i];
        CfgPowerMax:  reg_power_max  = val[i];
        default: ;
      endcase
      reg_writes++;
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_unlocked_words();
    tick_t t;
    t = '0;
    send_word(t);
    t = '{offset: 32'hFFFF_FFFF, sync: 32'h0, trim: 8'sh7F, tdelta: 16'sh7FFF,
          lstart: 16'hFFFF, lend: 16'h0};
    send_word(t);
    t = '{offset: 32'h0, sync: 32'hFFFF_FFFF, trim: -8'sd128, tdelta: -16'sd32768,
          lstart: 16'h0, lend: 16'hFFFF};
    send_word(t);
    // one short of and one past the arming difference
    t = '{offset: 32'd1011, sync: 32'd1000, trim: 8'sd5, tdelta: 16'sd100,
          lstart: 16'd4, lend: 16'd0};
    send_word(t);
    t = '{offset: 32'd1013, sync: 32'd1000, trim: -8'sd5, tdelta: -16'sd100,
          lstart: 16'd316, lend: 16'd0};
    send_word(t);
    t = '{offset: 32'hAAAA_AAAA, sync: 32'h5555_5555, trim: 8'sh55, tdelta: 16'h5555,
          lstart: 16'd500, lend: 16'd500};
    send_word(t);
    t = '{offset: 32'h5555_5555, sync: 32'hAAAA_AAAA, trim: -8'sh56, tdelta: 16'sh2AAA,
          lstart: 16'd1156, lend: 16'd1000};
    send_word(t);
  endtask

  task automatic test_lock_and_slips();
    tick_t t;
    int          devs  [9] = '{-12, 40, -40, 32767, -32768, 5, 100, -100, 12};
    int unsigned highs [9] = '{0, 0, 0, 0, 0, 3, 0, 0, 0};
    t = '0;
    t.sync   = $urandom;
    t.offset = t.sync + ArmOffset;
    send_word(t);
    send_offset(11, 0, t);
    send_offset(-11, 0, t);
    t.trim = 8'sd127;
    send_offset(SlipLimit, 0, t);
    // lockout swallows the next large deviations, small ones leave it alone
    t.trim = 8'sd0;
    for (int i = 0; i < 9; i++) send_offset(devs[i], highs[i], t);
    t.trim = -8'sd128;
    send_offset(-32768, 0, t);
  endtask

  task automatic test_power_limits();
    tick_t t;
    t = '0;
    program_power(16'sh7FFF, -16'sd32768, 16'sh7FFF);
    t.tdelta = 16'sd1;
    send_offset(0, 0, t);
    t.tdelta = 16'sh7FFF;
    send_offset(0, 0, t);
    // crossed limits, max is checked first
    program_power(16'sd0, 16'sd100, -16'sd100);
    t.tdelta = 16'sd0;
    send_offset(0, 0, t);
    t.tdelta = -16'sd500;
    send_offset(0, 0, t);
    program_power(-16'sd32768, 16'sd7, 16'sd7);
    t.tdelta = -16'sd1;
    send_offset(0, 0, t);
  endtask

  task automatic test_random_phases();
    tick_t       t;
    int          span;
    int          lim;
    int          pick;
    int unsigned upper;
    int          near_devs [4] = '{-13, -12, 12, 13};
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin
          program_power(PwrW'($urandom), -16'sd32768, 16'sh7FFF);
          stall_mode <= StallLight;
          burst_max = 4;
          gap_max   = 3;
        end
        1: begin
          program_power(PwrW'($urandom), PwrW'(-1000 + int'($urandom_range(0, 999))),
                        PwrW'(1000 + int'($urandom_range(0, 999))));
          stall_mode <= StallPattern;
          burst_max = 1;
          gap_max   = 1;
        end
        2: begin
          program_power(PwrW'($urandom), 16'sd500, -16'sd500);
          stall_mode <= StallHeavy;
          burst_max = 16;
          gap_max   = 6;
        end
        3: begin
          program_power(PwrW'($urandom), PwrW'($urandom), PwrW'($urandom));
          stall_mode <= StallNone;
          burst_max = 1;
          gap_max   = 0;
        end
        default: begin
          program_power(BasePowerRst, PowerMinRst, PowerMaxRst);
          stall_mode <= StallLight;
          burst_max = 2;
          gap_max   = 8;
        end
      endcase
      burst_left = $urandom_range(1, burst_max);
      for (int i = 0; i < PhaseWords; i++) begin
        t.trim   = TrimW'($urandom);
        t.tdelta = PwrW'($urandom);
        lim = (words_sent / 3 < 340) ? words_sent / 3 : 340;
        if ($urandom_range(0, 3) == 0) begin
          t.lstart = LoadW'($urandom);
          t.lend   = LoadW'($urandom);
        end else begin
          span     = $urandom_range(0, lim);
          t.lend   = LoadW'($urandom_range(0, 65535 - span));
          t.lstart = t.lend + LoadW'(span);
        end
        upper = ($urandom_range(0, 3) == 0) ? $urandom : 0;
        pick  = $urandom_range(0, 99);
        if (pick < 10) begin
          t.offset = $urandom;
          t.sync   = $urandom;
          send_word(t);
        end else if (pick < 65) begin
          send_offset(int'($urandom_range(0, 22)) - 11, upper, t);
        end else if (pick < 85) begin
          send_offset(near_devs[$urandom_range(0, 3)], upper, t);
        end else begin
          send_offset(int'($signed(16'($urandom))), upper, t);
        end
      end
    end
  endtask

  task automatic test_output_hold();
    tick_t t;
    t = '0;
    drain_results();
    stall_mode <= StallNone;
    gap_max = 0;
    fork
      begin
        hold_on <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_on <= 1'b0;
      end
    join_none
    for (int i = 0; i < 40; i++) begin
      t.trim   = TrimW'($urandom);
      t.tdelta = PwrW'($urandom);
      send_offset(int'($urandom_range(0, 30)) - 15, 0, t);
    end
    drain_results();
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    offset_count_i = '0;
    sync_count_i   = '0;
    length_trim_i  = '0;
    temp_delta_i   = '0;
    load_start_i   = '0;
    load_end_i     = '0;
    hold_on        = 1'b0;
    valid_high     = 1'b0;
    stall_mode     = StallLight;
    burst_max      = 3;
    gap_max        = 2;
    burst_left     = 1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unlocked_words();
    test_lock_and_slips();
    test_power_limits();
    test_random_phases();
    test_output_hold();

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("sent %0d burst words, checked %0d results, %0d slips, %0d register writes",
             words_sent, results_seen, slips_seen, reg_writes);
    $display("arming, lockout, power clamps, load peak and output hold; %0d mismatches, %0d left pending",
             mismatches, burst_results_q.size());
    if (mismatches == 0 && burst_results_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/bdst_pkg.sv
rtl/core/bdst_slip.sv
rtl/core/bdst_power.sv
rtl/core/bdst_load.sv
rtl/core/burst_dma_slip_tracker.sv
tb/sv/burst_dma_slip_tracker_tb.sv
